// ===== sv/kibm_pkg.sv =====
package kibm_pkg;

  localparam int FUNC_W   = 3;
  localparam int KMER_W   = 15;
  localparam int IDX_W    = 6;
  localparam int CNT_W    = 16;
  localparam int SCORE_W  = 15;
  localparam int RANK_W   = 3;
  localparam int REFS_W   = 7;
  localparam int RC_W     = 7;
  localparam int RES_W    = 4;
  localparam int RES_LIMIT = 8;
  localparam int DIV_W    = 32;

  localparam logic [SCORE_W-1:0] SCORE_FULL = 15'd25600;
  localparam logic [CNT_W-1:0]   CNT_MAX    = 16'hFFFF;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FUNC_REF_KMER  = 3'd0;
  localparam func_t FUNC_END_REF   = 3'd1;
  localparam func_t FUNC_QRY_KMER  = 3'd2;
  localparam func_t FUNC_END_QUERY = 3'd3;
  localparam func_t FUNC_COUNT     = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]   seq_index;
    logic [CNT_W-1:0]   match_count;
    logic [SCORE_W-1:0] score_pct;
    logic [RANK_W-1:0]  rank;
    logic               found;
    logic [REFS_W-1:0]  refs_with_kmer;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic apply;
    logic clr_step;
    logic clr_presence;
    logic pop_step;
    logic scan_step;
    logic mul;
    logic div_start;
    logic out_load;
    logic out_done;
  } cmd_t;

  typedef struct packed {
    logic  clr_done;
    logic  scan_done;
    logic  div_done;
    logic  n_zero;
    logic  out_last;
    func_t func;
  } sts_t;

endpackage

// ===== sv/kibm_in_if.sv =====
interface kibm_in_if import kibm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [KMER_W-1:0]   kmer_number;

  modport source (output valid, func, kmer_number, input ready);
  modport sink (input valid, func, kmer_number, output ready);
endinterface

// ===== sv/kibm_out_if.sv =====
interface kibm_out_if import kibm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   seq_index;
  logic [CNT_W-1:0]   match_count;
  logic [SCORE_W-1:0] score_pct;
  logic [RANK_W-1:0]  rank;
  logic               found;
  logic [REFS_W-1:0]  refs_with_kmer;
  logic               last;

  modport source (output valid, seq_index, match_count, score_pct, rank, found,
                  refs_with_kmer, last, input ready);
  modport sink (input valid, seq_index, match_count, score_pct, rank, found,
                refs_with_kmer, last, output ready);
endinterface

// ===== sv/kibm_cfg_if.sv =====
interface kibm_cfg_if import kibm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] num_results;

  modport source (output valid, num_results, input ready);
  modport sink (input valid, num_results, output ready);
endinterface

// ===== sv/kibm_ram.sv =====
module kibm_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/kibm_div.sv =====
module kibm_div import kibm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quot_o,
  output logic             done_o
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  q_q;
  logic [CNT_W-1:0]  r_q;
  logic [CNT_W-1:0]  d_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic [CNT_W:0]    rs;
  logic              fits;

  assign rs   = {r_q, q_q[DIV_W-1]};
  assign fits = rs >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[DIV_W-2:0], fits};
      r_q <= fits ? CNT_W'(rs - {1'b0, d_q}) : rs[CNT_W-1:0];
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

endmodule

// ===== sv/kibm_dp.sv =====
module kibm_dp import kibm_pkg::*; #(
  parameter int KMER_SIZE = 7,
  parameter int MAX_REFS  = 64,
  parameter int TOP_N     = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [FUNC_W-1:0] in_func_i,
  input  logic [KMER_W-1:0] in_kmer_i,
  input  logic              cfg_we_i,
  input  logic [RES_W-1:0]  cfg_data_i,
  output out_item_t         out_o
);

  localparam logic [31:0] MAX_KMER = 32'(1) << (2 * KMER_SIZE);
  localparam int MAP_DEPTH = int'(MAX_KMER) + 1;
  localparam int AW        = $clog2(MAP_DEPTH);
  localparam int SCAN_W    = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int LIMIT     = (TOP_N < RES_LIMIT) ? TOP_N : RES_LIMIT;

  func_t               func_q;
  logic [KMER_W-1:0]   kmer_q;
  logic                inrange_q;
  logic [RC_W-1:0]     ref_count_q;
  logic [CNT_W-1:0]    qk_q;
  logic [RES_W-1:0]    num_results_q;
  logic [CNT_W-1:0]    cnt_q [MAX_REFS];
  logic [MAX_REFS-1:0] picked_q;
  logic [SCAN_W-1:0]   scan_q;
  logic                have_q;
  logic [IDX_W-1:0]    best_q;
  logic [CNT_W-1:0]    bestc_q;
  logic [RANK_W-1:0]   rank_q;
  logic [RES_W-1:0]    n_q;
  logic [MAX_REFS-1:0] pop_row_q;
  logic [REFS_W-1:0]   pop_cnt_q;
  logic [DIV_W-1:0]    prod_q;
  logic [AW-1:0]       clr_addr_q;
  out_item_t           out_q;

  logic [MAX_REFS-1:0] done_mask;
  logic [MAX_REFS-1:0] ref_bit;
  logic [MAX_REFS-1:0] prd;
  logic [0:0]          srd;
  logic [MAX_REFS-1:0] qrow;
  logic                p_we;
  logic [AW-1:0]       p_waddr;
  logic [MAX_REFS-1:0] p_wdata;
  logic                s_we;
  logic [AW-1:0]       s_waddr;
  logic [0:0]          s_wdata;
  logic                in_range;
  logic                clear_query;
  logic                scan_done;
  logic                cand;
  logic [RES_W-1:0]    nr;
  logic [RC_W-1:0]     n_calc;
  logic [DIV_W-1:0]    quot;
  logic                div_done;
  logic [SCORE_W-1:0]  score;

  for (genvar i = 0; i < MAX_REFS; i++) begin : g_lane
    assign done_mask[i] = RC_W'(i) < ref_count_q;
    assign ref_bit[i]   = RC_W'(i) == ref_count_q;
  end

  assign in_range  = 32'(in_kmer_i) <= MAX_KMER;
  assign scan_done = scan_q == SCAN_W'(MAX_REFS - 1);
  assign clear_query = cmd_i.out_done && out_q.last && (func_q == FUNC_END_QUERY);
  assign qrow = (inrange_q && !srd[0]) ? (prd & done_mask) : '0;

  assign cand = (RC_W'(scan_q) < ref_count_q) && !picked_q[0] &&
                (!have_q || (cnt_q[0] > bestc_q));

  always_comb begin
    nr = (num_results_q == '0) ? RES_W'(1) : num_results_q;
    n_calc = RC_W'(nr);
    if (n_calc > ref_count_q) begin
      n_calc = ref_count_q;
    end
    if (n_calc > RC_W'(LIMIT)) begin
      n_calc = RC_W'(LIMIT);
    end
  end

  always_comb begin
    if (qk_q == '0) begin
      score = '0;
    end else if (quot > DIV_W'(SCORE_FULL)) begin
      score = SCORE_FULL;
    end else begin
      score = quot[SCORE_W-1:0];
    end
  end

  // memory write ports
  assign p_we = (cmd_i.clr_step && cmd_i.clr_presence) ||
                (cmd_i.apply && func_q == FUNC_REF_KMER && inrange_q &&
                 ref_count_q < RC_W'(MAX_REFS));
  assign p_waddr = cmd_i.clr_step ? clr_addr_q : AW'(kmer_q);
  assign p_wdata = cmd_i.clr_step ? '0 : (prd | ref_bit);
  assign s_we = cmd_i.clr_step ||
                (cmd_i.apply && func_q == FUNC_QRY_KMER && inrange_q && !srd[0]);
  assign s_waddr = cmd_i.clr_step ? clr_addr_q : AW'(kmer_q);
  assign s_wdata = cmd_i.clr_step ? 1'b0 : 1'b1;

  kibm_ram #(.W(MAX_REFS), .D(MAP_DEPTH)) u_presence (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (AW'(in_kmer_i)),
    .rdata_o (prd)
  );

  kibm_ram #(.W(1), .D(MAP_DEPTH)) u_seen (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (AW'(in_kmer_i)),
    .rdata_o (srd)
  );

  kibm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q + DIV_W'(qk_q >> 1)),
    .divisor_i  (qk_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q   <= '0;
      qk_q          <= '0;
      num_results_q <= RES_W'(1);
      clr_addr_q    <= '0;
      func_q        <= FUNC_REF_KMER;
      scan_q        <= '0;
      have_q        <= 1'b0;
      rank_q        <= '0;
      n_q           <= '0;
      picked_q      <= '0;
      for (int i = 0; i < MAX_REFS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        num_results_q <= cfg_data_i;
      end
      if (cmd_i.take) begin
        func_q <= in_func_i;
        if (in_func_i == FUNC_END_REF && ref_count_q < RC_W'(MAX_REFS)) begin
          ref_count_q <= ref_count_q + RC_W'(1);
        end
        if (in_func_i == FUNC_QRY_KMER && qk_q != CNT_MAX) begin
          qk_q <= qk_q + CNT_W'(1);
        end
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= sts_o.clr_done ? '0 : clr_addr_q + AW'(1);
      end
      if (cmd_i.apply) begin
        scan_q <= '0;
        have_q <= 1'b0;
        rank_q <= '0;
        n_q    <= RES_W'(n_calc);
        if (func_q == FUNC_END_QUERY) begin
          picked_q <= '0;
        end
      end
      if (cmd_i.pop_step) begin
        scan_q <= scan_q + SCAN_W'(1);
      end
      if (cmd_i.scan_step) begin
        scan_q <= scan_q + SCAN_W'(1);
        if (cand) begin
          have_q <= 1'b1;
        end
        for (int i = 0; i < MAX_REFS; i++) begin
          picked_q[i] <= picked_q[(i + 1) % MAX_REFS];
        end
      end
      if (cmd_i.mul) begin
        picked_q[best_q[SCAN_W-1:0]] <= 1'b1;
      end
      if (cmd_i.out_done) begin
        rank_q <= rank_q + RANK_W'(1);
        scan_q <= '0;
        have_q <= 1'b0;
      end
      if (clear_query) begin
        qk_q       <= '0;
        clr_addr_q <= '0;
        for (int i = 0; i < MAX_REFS; i++) begin
          cnt_q[i] <= '0;
        end
      end else if (cmd_i.scan_step) begin
        for (int i = 0; i < MAX_REFS; i++) begin
          cnt_q[i] <= cnt_q[(i + 1) % MAX_REFS];
        end
      end else if (cmd_i.apply && func_q == FUNC_QRY_KMER) begin
        for (int i = 0; i < MAX_REFS; i++) begin
          if (qrow[i] && cnt_q[i] != CNT_MAX) begin
            cnt_q[i] <= cnt_q[i] + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kmer_q    <= in_kmer_i;
      inrange_q <= in_range;
    end
    if (cmd_i.scan_step && cand) begin
      best_q  <= IDX_W'(scan_q);
      bestc_q <= cnt_q[0];
    end
    if (cmd_i.mul) begin
      prod_q <= DIV_W'(bestc_q) * DIV_W'(SCORE_FULL);
    end
    if (cmd_i.apply) begin
      pop_row_q <= inrange_q ? (prd & done_mask) : '0;
      pop_cnt_q <= '0;
    end
    if (cmd_i.pop_step) begin
      pop_row_q <= pop_row_q >> 1;
      pop_cnt_q <= pop_cnt_q + REFS_W'(pop_row_q[0]);
    end
    if (cmd_i.apply && func_q == FUNC_END_QUERY && ref_count_q == '0) begin
      out_q      <= '0;
      out_q.last <= 1'b1;
    end
    if (cmd_i.pop_step && scan_done) begin
      out_q                <= '0;
      out_q.found          <= ref_count_q != '0;
      out_q.refs_with_kmer <= pop_cnt_q + REFS_W'(pop_row_q[0]);
      out_q.last           <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.seq_index      <= best_q;
      out_q.match_count    <= bestc_q;
      out_q.score_pct      <= score;
      out_q.rank           <= rank_q;
      out_q.found          <= 1'b1;
      out_q.refs_with_kmer <= '0;
      out_q.last           <= ({1'b0, rank_q} + RES_W'(1)) == n_q;
    end
  end

  assign sts_o.clr_done  = clr_addr_q == AW'(MAP_DEPTH - 1);
  assign sts_o.scan_done = scan_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.n_zero    = ref_count_q == '0;
  assign sts_o.out_last  = out_q.last;
  assign sts_o.func      = func_q;
  assign out_o           = out_q;

  a_ref_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_count_q <= RC_W'(MAX_REFS))
    else $error("reference count beyond capacity");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> ({1'b0, rank_q} < n_q))
    else $error("selection running past the result count");

  a_clear_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(clr_addr_q) < 32'(MAP_DEPTH))
    else $error("clear address out of range");

endmodule

// ===== sv/kibm_ctrl.sv =====
module kibm_ctrl import kibm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APPLY, S_POP, S_SCAN, S_MUL, S_DSTART, S_DIV, S_OUT, S_QCLR
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step     = 1'b1;
        cmd_o.clr_presence = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        case (sts_i.func)
          FUNC_COUNT:     state_d = S_POP;
          FUNC_END_QUERY: state_d = sts_i.n_zero ? S_OUT : S_SCAN;
          default:        state_d = S_IDLE;
        endcase
      end
      S_POP: begin
        cmd_o.pop_step = 1'b1;
        if (sts_i.scan_done) state_d = S_OUT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          cmd_o.out_done = 1'b1;
          if (!sts_i.out_last) begin
            state_d = S_SCAN;
          end else if (sts_i.func == FUNC_END_QUERY) begin
            state_d = S_QCLR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_QCLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;

endmodule

// ===== sv/kmer_index_best_match_unit.sv =====
// channel  dir  port   payload
// input    in   in_i   func, kmer_number
// result   out  out_o  seq_index, match_count, score_pct, rank, found, refs_with_kmer, last
// config   in   cfg_i  num_results
//
// reference kmer, end of reference, query kmer: take, then apply (presence map read port)
// count query: take, apply, then a bit-serial popcount of one map row to the result
// end of query: per result a counter ring scan, a multiply and a 32-step divider,
//   then a seen-map clearing pass over 4^KMER_SIZE + 1 addresses (16385 by default)
// after reset a clearing pass over 4^KMER_SIZE + 1 addresses runs before input is taken
// a waiting result holds the block; config is taken in any cycle
module kmer_index_best_match_unit import kibm_pkg::*; #(
  parameter int KMER_SIZE = 7,
  parameter int MAX_REFS  = 64,
  parameter int TOP_N     = 8
) (
  input logic          clk_i,
  input logic          rst_ni,
  kibm_in_if.sink      in_i,
  kibm_out_if.source   out_o,
  kibm_cfg_if.sink     cfg_i
);

  cmd_t      cmd;
  sts_t      sts;
  out_item_t item;

  assign cfg_i.ready = 1'b1;

  kibm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kibm_dp #(
    .KMER_SIZE (KMER_SIZE),
    .MAX_REFS  (MAX_REFS),
    .TOP_N     (TOP_N)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_func_i  (in_i.func),
    .in_kmer_i  (in_i.kmer_number),
    .cfg_we_i   (cfg_i.valid),
    .cfg_data_i (cfg_i.num_results),
    .out_o      (item)
  );

  assign out_o.seq_index      = item.seq_index;
  assign out_o.match_count    = item.match_count;
  assign out_o.score_pct      = item.score_pct;
  assign out_o.rank           = item.rank;
  assign out_o.found          = item.found;
  assign out_o.refs_with_kmer = item.refs_with_kmer;
  assign out_o.last           = item.last;

endmodule

// ===== verif/kmer_index_best_match_unit_test.sv =====
module kmer_index_best_match_unit_test;
  import kibm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_KMER   = 16384;
  localparam int MAP_DEPTH  = MAX_KMER + 1;
  localparam int REF_SLOTS  = 64;
  localparam int BEST_MAX   = 8;
  localparam int SETTLE     = 16600;
  localparam int LIMIT      = 3000000;

  typedef struct {
    func_t            func;
    logic [KMER_W-1:0] kmer;
  } kmer_item_t;

  logic clk_i;
  logic rst_ni;

  kibm_in_if  in_ch();
  kibm_out_if out_ch();
  kibm_cfg_if cfg_ch();

  kmer_index_best_match_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  kmer_item_t pending_items[$];
  out_item_t  expected_matches[$];

  bit [63:0]   presence_rows [MAP_DEPTH];
  bit          kmer_seen [MAP_DEPTH];
  int unsigned ref_hits [REF_SLOTS];
  int unsigned loaded_refs;
  int unsigned query_kmers;
  int unsigned best_wanted;

  int unsigned errors;
  int unsigned cycles;
  int          burst_left;
  int          gap_left;
  int          ready_mode;
  int          ready_phase;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit [63:0] finished_mask();
    if (loaded_refs >= REF_SLOTS) return '1;
    return (64'd1 << loaded_refs) - 64'd1;
  endfunction

  task automatic predict_kmer_index(func_t f, logic [KMER_W-1:0] k);
    bit          in_range;
    bit [63:0]   row;
    bit [63:0]   picked;
    int unsigned n;
    int unsigned best;
    int unsigned best_cnt;
    bit          have;
    longint unsigned score;
    out_item_t   res;
    in_range = k <= MAX_KMER;
    res = '0;
    case (f)
      FUNC_REF_KMER: begin
        if (loaded_refs < REF_SLOTS && in_range) presence_rows[k][loaded_refs] = 1'b1;
      end
      FUNC_END_REF: begin
        if (loaded_refs < REF_SLOTS) loaded_refs++;
      end
      FUNC_QRY_KMER: begin
        if (query_kmers < 65535) query_kmers++;
        if (in_range && !kmer_seen[k]) begin
          kmer_seen[k] = 1'b1;
          row = presence_rows[k] & finished_mask();
          for (int i = 0; i < REF_SLOTS; i++)
            if (row[i] && ref_hits[i] < 65535) ref_hits[i]++;
        end
      end
      FUNC_END_QUERY: begin
        n = best_wanted == 0 ? 1 : best_wanted;
        if (n > loaded_refs) n = loaded_refs;
        if (n > BEST_MAX) n = BEST_MAX;
        if (n == 0) begin
          res.last = 1'b1;
          expected_matches = {expected_matches, res};
        end
        picked = '0;
        for (int r = 0; r < n; r++) begin
          have = 1'b0;
          best = 0;
          best_cnt = 0;
          for (int i = 0; i < loaded_refs && i < REF_SLOTS; i++) begin
            if (picked[i]) continue;
            if (!have || ref_hits[i] > best_cnt) begin
              have = 1'b1;
              best = i;
              best_cnt = ref_hits[i];
            end
          end
          picked[best] = 1'b1;
          score = 0;
          if (query_kmers != 0) begin
            score = (longint'(best_cnt) * 25600 + query_kmers / 2) / query_kmers;
            if (score > 25600) score = 25600;
          end
          res = '0;
          res.seq_index   = best[IDX_W-1:0];
          res.match_count = best_cnt[CNT_W-1:0];
          res.score_pct   = score[SCORE_W-1:0];
          res.rank        = r[RANK_W-1:0];
          res.found       = 1'b1;
          res.last        = (r + 1 == n);
          expected_matches = {expected_matches, res};
        end
        foreach (kmer_seen[i]) kmer_seen[i] = 1'b0;
        foreach (ref_hits[i]) ref_hits[i] = 0;
        query_kmers = 0;
      end
      FUNC_COUNT: begin
        res.found = loaded_refs > 0;
        res.refs_with_kmer = in_range ?
                             REFS_W'($countones(presence_rows[k] & finished_mask())) : '0;
        res.last = 1'b1;
        expected_matches = {expected_matches, res};
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.func        <= FUNC_REF_KMER;
      in_ch.kmer_number <= '0;
      burst_left        = 0;
      gap_left          = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_kmer_index(pending_items[0].func, pending_items[0].kmer);
        void'(pending_items.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.valid       <= 1'b1;
          in_ch.func        <= pending_items[0].func;
          in_ch.kmer_number <= pending_items[0].kmer;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t got;
    out_item_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ready_mode   = 0;
      ready_phase  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.seq_index      = out_ch.seq_index;
        got.match_count    = out_ch.match_count;
        got.score_pct      = out_ch.score_pct;
        got.rank           = out_ch.rank;
        got.found          = out_ch.found;
        got.refs_with_kmer = out_ch.refs_with_kmer;
        got.last           = out_ch.last;
        if (expected_matches.size() == 0) begin
          report_mismatch("unexpected result, seq_index", got.seq_index, 0);
        end else begin
          want = expected_matches.pop_front();
          if (got.seq_index != want.seq_index)
            report_mismatch("seq_index", got.seq_index, want.seq_index);
          if (got.match_count != want.match_count)
            report_mismatch("match_count", got.match_count, want.match_count);
          if (got.score_pct != want.score_pct)
            report_mismatch("score_pct", got.score_pct, want.score_pct);
          if (got.rank != want.rank)
            report_mismatch("rank", got.rank, want.rank);
          if (got.found != want.found)
            report_mismatch("found", got.found, want.found);
          if (got.refs_with_kmer != want.refs_with_kmer)
            report_mismatch("refs_with_kmer", got.refs_with_kmer, want.refs_with_kmer);
          if (got.last != want.last)
            report_mismatch("last", got.last, want.last);
        end
      end
      ready_phase++;
      if (ready_phase >= 150) begin
        ready_phase = 0;
        ready_mode = $urandom_range(0, 3);
      end
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= (ready_phase % 9) > 5;
        default: out_ch.ready <= (ready_phase % 40) == 0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** kmer_index_best_match_unit: FAILED **");
      $finish;
    end
  end

  task automatic add_item(func_t f, int unsigned k);
    kmer_item_t it;
    it.func = f;
    it.kmer = k[KMER_W-1:0];
    pending_items = {pending_items, it};
  endtask

  function automatic int unsigned pick_kmer();
    case ($urandom_range(0, 9))
      0: return MAX_KMER;
      1: return $urandom_range(0, 32767);
      2: return $urandom_range(MAX_KMER - 8, MAX_KMER);
      default: return $urandom_range(0, 23);
    endcase
  endfunction

  task automatic add_query(int unsigned len);
    int unsigned k;
    for (int i = 0; i < len; i++) begin
      k = pick_kmer();
      add_item(FUNC_QRY_KMER, k);
      if ($urandom_range(0, 3) == 0) add_item(FUNC_QRY_KMER, k);
    end
    add_item(FUNC_END_QUERY, 0);
  endtask

  task automatic add_phase();
    int unsigned nref;
    nref = $urandom_range(9, 14);
    for (int r = 0; r < nref; r++) begin
      for (int j = $urandom_range(1, 2); j > 0; j--) add_item(FUNC_REF_KMER, pick_kmer());
      if (r != nref - 1) add_item(FUNC_END_REF, 0);
    end
    // last slot still open across this query
    add_item(FUNC_COUNT, pick_kmer());
    add_query($urandom_range(2, 6));
    add_item(FUNC_END_REF, 0);
    if ($urandom_range(0, 2) == 0) add_item(func_t'($urandom_range(5, 7)), $urandom_range(0, 32767));
    add_query($urandom_range(2, 6));
    add_item(FUNC_COUNT, pick_kmer());
    add_item(FUNC_COUNT, $urandom_range(0, 32767));
    // broken sequence: query without its end, then a fresh query
    for (int j = $urandom_range(1, 3); j > 0; j--) add_item(FUNC_QRY_KMER, pick_kmer());
    add_query($urandom_range(2, 4));
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || expected_matches.size() != 0 || in_ch.valid);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_best_count(int unsigned v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.num_results <= v[RES_W-1:0];
    do @(posedge clk_i);
    while (!(cfg_ch.valid && cfg_ch.ready));
    best_wanted = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned settings[6];
    settings = '{8, 0, 15, 3, 5, 1};
    rst_ni             = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.num_results = '0;
    errors             = 0;
    cycles             = 0;
    loaded_refs        = 0;
    query_kmers        = 0;
    best_wanted        = 1;
    foreach (presence_rows[i]) presence_rows[i] = '0;
    foreach (kmer_seen[i]) kmer_seen[i] = 1'b0;
    foreach (ref_hits[i]) ref_hits[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // nothing loaded yet
    add_item(FUNC_COUNT, 5);
    add_item(FUNC_QRY_KMER, 5);
    add_item(FUNC_END_QUERY, 0);
    add_item(FUNC_REF_KMER, 0);
    add_item(FUNC_REF_KMER, MAX_KMER);
    add_item(FUNC_REF_KMER, 32767);
    add_item(FUNC_REF_KMER, 5);
    add_item(FUNC_END_REF, 0);
    add_item(FUNC_REF_KMER, 5);
    add_item(FUNC_REF_KMER, 10922);
    add_item(FUNC_END_REF, 0);
    add_item(FUNC_COUNT, 5);
    add_item(FUNC_COUNT, MAX_KMER);
    add_item(FUNC_COUNT, 32767);
    add_item(FUNC_QRY_KMER, 5);
    add_item(FUNC_QRY_KMER, 5);
    add_item(FUNC_QRY_KMER, MAX_KMER);
    add_item(FUNC_QRY_KMER, 32767);
    add_item(FUNC_QRY_KMER, 21845);
    add_item(FUNC_END_QUERY, 0);
    add_item(func_t'(5), 0);
    add_item(func_t'(6), 21845);
    add_item(func_t'(7), 10922);
    wait_idle();

    foreach (settings[s]) begin
      write_best_count(settings[s]);
      add_phase();
      wait_idle();
    end

    if (errors == 0) begin
      $display("** kmer_index_best_match_unit: PASSED **");
    end else begin
      $display("** kmer_index_best_match_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/kibm_pkg.sv
sv/kibm_in_if.sv
sv/kibm_out_if.sv
sv/kibm_cfg_if.sv
sv/kibm_ram.sv
sv/kibm_div.sv
sv/kibm_dp.sv
sv/kibm_ctrl.sv
sv/kmer_index_best_match_unit.sv
verif/kmer_index_best_match_unit_test.sv
